@@ hw/rtl/saq_pkg.sv @@
// Shared types and constants for the sorted alarm queue.
package saq_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TIME_W = 32;
  localparam int SES_W  = 32;
  localparam int ALM_W  = 16;
  localparam int RCNT_W = 6;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_PURGE  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [SES_W-1:0]  session;
    logic [ALM_W-1:0]  alarm;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_RESP
  } state_t;

endpackage

@@ hw/rtl/sorted_alarm_queue.sv @@
// Sorted alarm queue: entry memory, walk sequencer and result register.
//
// Usage: an operation is a transfer on the input channel (in_valid high,
// in_stall low) carrying opcode, now, delay, session and alarm_id.
// Every operation produces exactly one result transfer on the output
// channel (out_valid high, out_stall low).
// The single read port of the entry memory steps one entry per cycle, and
// in_stall stays high until the result moves into the output register, so
// no new operation is taken while one is still in the sequencer.
// Add walks from the tail toward the head shifting later entries up by
// one; cancel, pop and purge walk from the head, compacting kept entries.
// A finished result sits in the output register; while the receiver
// holds out_stall high the next operation may still be taken, but its
// result waits in the sequencer until the output register frees up.
// Reset (rst, synchronous) empties the queue and drops any pending
// result. The entry memory is not cleared; only entries below the
// occupancy count are ever read.
module sorted_alarm_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 opcode,
  input  logic [saq_pkg::TIME_W-1:0] now,
  input  logic [saq_pkg::TIME_W-1:0] delay,
  input  logic [saq_pkg::SES_W-1:0]  session,
  input  logic [saq_pkg::ALM_W-1:0]  alarm_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [saq_pkg::SES_W-1:0]  out_session,
  output logic [saq_pkg::ALM_W-1:0]  out_alarm,
  output logic [saq_pkg::TIME_W-1:0] out_expiry,
  output logic [saq_pkg::RCNT_W-1:0] removed_count
);

  saq_pkg::state_t state, state_next;

  saq_pkg::entry_t entry_mem [saq_pkg::DEPTH];
  saq_pkg::entry_t rd_data;
  saq_pkg::entry_t wr_data;
  saq_pkg::entry_t new_entry;
  logic                       rd_en;
  logic [saq_pkg::IDX_W-1:0]  rd_addr;
  logic                       wr_en;
  logic [saq_pkg::IDX_W-1:0]  wr_addr;

  logic [saq_pkg::CNT_W-1:0]  occupancy, occupancy_next;
  logic [saq_pkg::CNT_W-1:0]  rd_idx, rd_idx_next;
  logic                       pend, pend_next;
  logic [saq_pkg::IDX_W-1:0]  pend_idx, pend_idx_next;
  logic [saq_pkg::CNT_W-1:0]  keep, keep_next;
  logic [saq_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic                       found, found_next;
  logic [1:0]                 res_status, res_status_next;
  saq_pkg::entry_t            res_entry, res_entry_next;

  logic [1:0]                 op_q;
  logic [saq_pkg::TIME_W-1:0] now_q;
  logic [saq_pkg::TIME_W-1:0] exp_q;
  logic [saq_pkg::SES_W-1:0]  ses_q;
  logic [saq_pkg::ALM_W-1:0]  alm_q;

  logic                       in_xfer;
  logic                       load_out;
  logic [saq_pkg::TIME_W:0]   sum_full;
  logic [saq_pkg::TIME_W-1:0] exp_in;

  // saturating expiry of a new alarm
  assign sum_full = {1'b0, now} + {1'b0, delay};
  assign exp_in   = sum_full[saq_pkg::TIME_W] ? '1 : sum_full[saq_pkg::TIME_W-1:0];

  assign new_entry.expiry  = exp_q;
  assign new_entry.session = ses_q;
  assign new_entry.alarm   = alm_q;

  assign in_xfer = in_valid && !in_stall;

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= entry_mem[rd_addr];
    end
  end

  // hold the operands of the accepted operation
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q  <= opcode;
      now_q <= now;
      exp_q <= exp_in;
      ses_q <= session;
      alm_q <= alarm_id;
    end
  end

  // state and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= saq_pkg::S_IDLE;
      occupancy <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      pend      <= pend_next;
      found     <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    pend_idx   <= pend_idx_next;
    keep       <= keep_next;
    cnt        <= cnt_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
  end

  // sequencer: next state, memory controls and walk bookkeeping
  always_comb begin
    logic drop_hit;
    drop_hit        = 1'b0;
    state_next      = state;
    occupancy_next  = occupancy;
    rd_idx_next     = rd_idx;
    pend_next       = 1'b0;
    pend_idx_next   = pend_idx;
    keep_next       = keep;
    cnt_next        = cnt;
    found_next      = found;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    rd_en           = 1'b0;
    rd_addr         = rd_idx[saq_pkg::IDX_W-1:0];
    wr_en           = 1'b0;
    wr_addr         = keep[saq_pkg::IDX_W-1:0];
    wr_data         = rd_data;
    load_out        = 1'b0;
    in_stall        = (state != saq_pkg::S_IDLE);

    case (state)
      saq_pkg::S_IDLE: begin
        if (in_valid) begin
          found_next = 1'b0;
          cnt_next   = '0;
          keep_next  = '0;
          if (opcode == saq_pkg::OP_ADD) begin
            if (occupancy == saq_pkg::CNT_W'(saq_pkg::DEPTH)) begin
              res_status_next = saq_pkg::ST_FULL;
              state_next      = saq_pkg::S_RESP;
            end else begin
              rd_idx_next = occupancy;
              state_next  = saq_pkg::S_INS;
            end
          end else begin
            rd_idx_next = '0;
            state_next  = saq_pkg::S_SCAN;
          end
        end
      end

      saq_pkg::S_INS: begin
        // read the next entry toward the head
        if (rd_idx != '0) begin
          rd_en         = 1'b1;
          rd_addr       = saq_pkg::IDX_W'(rd_idx - saq_pkg::CNT_W'(1));
          rd_idx_next   = rd_idx - saq_pkg::CNT_W'(1);
          pend_next     = 1'b1;
          pend_idx_next = rd_addr;
        end
        // shift a later entry up, or drop the new one in behind it
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx + saq_pkg::IDX_W'(1);
          if (rd_data.expiry > exp_q) begin
            wr_data = rd_data;
          end else begin
            wr_data         = new_entry;
            pend_next       = 1'b0;
            occupancy_next  = occupancy + saq_pkg::CNT_W'(1);
            res_status_next = saq_pkg::ST_DONE;
            state_next      = saq_pkg::S_RESP;
          end
        end else if (rd_idx == '0) begin
          wr_en           = 1'b1;
          wr_addr         = '0;
          wr_data         = new_entry;
          occupancy_next  = occupancy + saq_pkg::CNT_W'(1);
          res_status_next = saq_pkg::ST_DONE;
          state_next      = saq_pkg::S_RESP;
        end
      end

      saq_pkg::S_SCAN: begin
        // read the next entry toward the tail
        if (rd_idx < occupancy) begin
          rd_en         = 1'b1;
          rd_addr       = rd_idx[saq_pkg::IDX_W-1:0];
          rd_idx_next   = rd_idx + saq_pkg::CNT_W'(1);
          pend_next     = 1'b1;
          pend_idx_next = rd_addr;
        end
        if (pend) begin
          case (op_q)
            saq_pkg::OP_CANCEL:
              drop_hit = !found && (rd_data.session == ses_q) && (rd_data.alarm == alm_q);
            saq_pkg::OP_POP:
              drop_hit = (pend_idx == '0) && (rd_data.expiry < now_q);
            saq_pkg::OP_PURGE:
              drop_hit = (rd_data.session == ses_q);
            default:
              drop_hit = 1'b0;
          endcase
          // drop a matching entry, or compact a kept one down
          if (drop_hit) begin
            cnt_next = cnt + saq_pkg::CNT_W'(1);
            if (op_q != saq_pkg::OP_PURGE) begin
              found_next     = 1'b1;
              res_entry_next = rd_data;
            end
          end else begin
            wr_en     = 1'b1;
            wr_addr   = keep[saq_pkg::IDX_W-1:0];
            wr_data   = rd_data;
            keep_next = keep + saq_pkg::CNT_W'(1);
          end
        end else if (rd_idx >= occupancy) begin
          occupancy_next  = keep;
          res_status_next = (op_q == saq_pkg::OP_PURGE || found) ?
                            saq_pkg::ST_DONE : saq_pkg::ST_NONE;
          state_next      = saq_pkg::S_RESP;
        end
      end

      saq_pkg::S_RESP: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = saq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = saq_pkg::S_IDLE;
      end
    endcase
  end

  // output register: advance on transfer, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= res_status;
      out_session   <= found ? res_entry.session : '0;
      out_alarm     <= found ? res_entry.alarm : '0;
      out_expiry    <= found ? res_entry.expiry : '0;
      removed_count <= (op_q == saq_pkg::OP_PURGE) ? saq_pkg::RCNT_W'(cnt) : '0;
    end
  end

endmodule

@@ bench/sorted_alarm_queue_tb.sv @@
// Self-checking testbench for sorted_alarm_queue: directed edge cases, then random operations.
`timescale 1ns / 100ps

module sorted_alarm_queue_tb;

  localparam int QUIET_LIMIT = 3000;

  // one expected result of an operation
  typedef struct packed {
    logic [1:0]                 status;
    logic [saq_pkg::SES_W-1:0]  session;
    logic [saq_pkg::ALM_W-1:0]  alarm;
    logic [saq_pkg::TIME_W-1:0] expiry;
    logic [saq_pkg::RCNT_W-1:0] count;
  } alarm_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 opcode = saq_pkg::OP_ADD;
  logic [saq_pkg::TIME_W-1:0] now = '0;
  logic [saq_pkg::TIME_W-1:0] delay = '0;
  logic [saq_pkg::SES_W-1:0]  session = '0;
  logic [saq_pkg::ALM_W-1:0]  alarm_id = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 status;
  logic [saq_pkg::SES_W-1:0]  out_session;
  logic [saq_pkg::ALM_W-1:0]  out_alarm;
  logic [saq_pkg::TIME_W-1:0] out_expiry;
  logic [saq_pkg::RCNT_W-1:0] removed_count;

  // predicted queue contents, head at index 0
  logic [saq_pkg::TIME_W-1:0] held_expiry [saq_pkg::DEPTH];
  logic [saq_pkg::SES_W-1:0]  held_session [saq_pkg::DEPTH];
  logic [saq_pkg::ALM_W-1:0]  held_alarm [saq_pkg::DEPTH];
  int                         held = 0;

  alarm_result_t              pending_results [$];
  int                         errors = 0;
  int                         quiet_cycles = 0;
  bit                         calm = 1'b0;
  logic [saq_pkg::TIME_W-1:0] tick = '0;
  logic [saq_pkg::SES_W-1:0]  session_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                  32'h0000_0001, 32'h8000_0000,
                                                  32'h1234_5678, 32'h5555_AAAA};

  sorted_alarm_queue dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .now           (now),
    .delay         (delay),
    .session       (session),
    .alarm_id      (alarm_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .out_session   (out_session),
    .out_alarm     (out_alarm),
    .out_expiry    (out_expiry),
    .removed_count (removed_count)
  );

  always #5 clk = ~clk;

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Close the gap left by the entry at pos
  function automatic void remove_entry(int pos);
    int i;
    for (i = pos; i + 1 < held; i++) begin
      held_expiry[i]  = held_expiry[i + 1];
      held_session[i] = held_session[i + 1];
      held_alarm[i]   = held_alarm[i + 1];
    end
    held--;
  endfunction

  // Apply one operation to the predicted queue and queue up its result
  function automatic void apply_alarm_op(logic [1:0] op, logic [saq_pkg::TIME_W-1:0] t_now,
                                         logic [saq_pkg::TIME_W-1:0] t_delay,
                                         logic [saq_pkg::SES_W-1:0] ses,
                                         logic [saq_pkg::ALM_W-1:0] alm);
    alarm_result_t              r;
    logic [saq_pkg::TIME_W:0]   sum;
    logic [saq_pkg::TIME_W-1:0] expiry;
    int                         pos, i, keep, hits;
    r = '0;
    r.status = saq_pkg::ST_DONE;
    case (op)
      saq_pkg::OP_ADD: begin
        sum = {1'b0, t_now} + {1'b0, t_delay};
        expiry = sum[saq_pkg::TIME_W] ? '1 : sum[saq_pkg::TIME_W-1:0];
        if (held >= saq_pkg::DEPTH) begin
          r.status = saq_pkg::ST_FULL;
        end else begin
          // equal expiries stay in arrival order
          pos = 0;
          while (pos < held && held_expiry[pos] <= expiry) pos++;
          for (i = held; i > pos; i--) begin
            held_expiry[i]  = held_expiry[i - 1];
            held_session[i] = held_session[i - 1];
            held_alarm[i]   = held_alarm[i - 1];
          end
          held_expiry[pos]  = expiry;
          held_session[pos] = ses;
          held_alarm[pos]   = alm;
          held++;
        end
      end
      saq_pkg::OP_CANCEL: begin
        pos = -1;
        for (i = 0; i < held && pos < 0; i++)
          if (held_session[i] == ses && held_alarm[i] == alm) pos = i;
        if (pos < 0) begin
          r.status = saq_pkg::ST_NONE;
        end else begin
          r.session = held_session[pos];
          r.alarm   = held_alarm[pos];
          r.expiry  = held_expiry[pos];
          remove_entry(pos);
        end
      end
      saq_pkg::OP_POP: begin
        if (held > 0 && held_expiry[0] < t_now) begin
          r.session = held_session[0];
          r.alarm   = held_alarm[0];
          r.expiry  = held_expiry[0];
          remove_entry(0);
        end else begin
          r.status = saq_pkg::ST_NONE;
        end
      end
      default: begin
        // compact the survivors in order
        keep = 0;
        hits = 0;
        for (i = 0; i < held; i++) begin
          if (held_session[i] == ses) begin
            hits++;
          end else begin
            held_expiry[keep]  = held_expiry[i];
            held_session[keep] = held_session[i];
            held_alarm[keep]   = held_alarm[i];
            keep++;
          end
        end
        held = keep;
        r.count = saq_pkg::RCNT_W'(hits);
      end
    endcase
    pending_results.push_back(r);
  endfunction

  // Drive one operation and hold it until the transfer happens
  task automatic send_op(logic [1:0] op, logic [saq_pkg::TIME_W-1:0] t_now,
                         logic [saq_pkg::TIME_W-1:0] t_delay,
                         logic [saq_pkg::SES_W-1:0] ses, logic [saq_pkg::ALM_W-1:0] alm);
    @(negedge clk);
    while (!calm && chance(23)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    now      <= t_now;
    delay    <= t_delay;
    session  <= ses;
    alarm_id <= alm;
    do @(posedge clk); while (in_stall);
    apply_alarm_op(op, t_now, t_delay, ses, alm);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver back-pressure: random stalls, none while calm
  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= chance(23);
    end
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin : check_result
    alarm_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d", status));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (out_session !== want.session)
          report_mismatch($sformatf("out_session %h, want %h", out_session, want.session));
        if (out_alarm !== want.alarm)
          report_mismatch($sformatf("out_alarm %h, want %h", out_alarm, want.alarm));
        if (out_expiry !== want.expiry)
          report_mismatch($sformatf("out_expiry %h, want %h", out_expiry, want.expiry));
        if (removed_count !== want.count)
          report_mismatch($sformatf("removed_count %0d, want %0d", removed_count, want.count));
      end
    end
  end

  // End the run if no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", QUIET_LIMIT);
      $display("sorted_alarm_queue_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [saq_pkg::TIME_W-1:0] pick_delay();
    case ($urandom_range(9))
      6, 7:    return '0;
      8:       return $urandom();
      9:       return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(40);
    endcase
  endfunction

  function automatic logic [saq_pkg::SES_W-1:0] pick_session();
    return chance(80) ? session_pool[$urandom_range(5)] : $urandom();
  endfunction

  function automatic logic [saq_pkg::ALM_W-1:0] pick_alarm();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 16'd1;
      4, 5:    return 16'd2;
      default: return saq_pkg::ALM_W'($urandom());
    endcase
  endfunction

  // One random operation, biased toward entries that are really queued
  task automatic send_random_op();
    int                         pick, idx, add_share;
    logic [saq_pkg::TIME_W-1:0] t;
    tick = tick + $urandom_range(6);
    if (chance(3)) tick = $urandom();
    add_share = (held < saq_pkg::DEPTH / 2) ? 50 : 30;
    pick = $urandom_range(99);
    if (pick < add_share) begin
      send_op(saq_pkg::OP_ADD, tick, pick_delay(), pick_session(), pick_alarm());
    end else if (pick < add_share + 22) begin
      if (held > 0 && chance(70)) begin
        idx = $urandom_range(held - 1);
        send_op(saq_pkg::OP_CANCEL, $urandom(), $urandom(), held_session[idx],
                held_alarm[idx]);
      end else begin
        send_op(saq_pkg::OP_CANCEL, $urandom(), $urandom(), pick_session(), pick_alarm());
      end
    end else if (pick < add_share + 40) begin
      // hit the strictly-earlier boundary on the head often
      t = (held > 0 && chance(50)) ?
          held_expiry[0] + saq_pkg::TIME_W'($urandom_range(1)) : tick;
      if (chance(5)) t = $urandom();
      send_op(saq_pkg::OP_POP, t, $urandom(), $urandom(), saq_pkg::ALM_W'($urandom()));
    end else begin
      if (held > 0 && chance(70)) begin
        idx = $urandom_range(held - 1);
        send_op(saq_pkg::OP_PURGE, $urandom(), $urandom(), held_session[idx],
                saq_pkg::ALM_W'($urandom()));
      end else begin
        send_op(saq_pkg::OP_PURGE, $urandom(), $urandom(), pick_session(),
                saq_pkg::ALM_W'($urandom()));
      end
    end
  endtask

  // Pop, cancel and purge on an empty queue
  task automatic test_empty_queue();
    send_op(saq_pkg::OP_POP, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0);
    send_op(saq_pkg::OP_CANCEL, 32'h0, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
    send_op(saq_pkg::OP_PURGE, 32'h0, 32'h0, 32'h0, 16'h0);
  endtask

  // Saturating expiry, equal-time order and the pop boundary
  task automatic test_add_edges();
    send_op(saq_pkg::OP_ADD, 32'hFFFF_FFF0, 32'h0000_0100, 32'hA5A5_A5A5, 16'h0001);
    send_op(saq_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 16'hFFFF);
    send_op(saq_pkg::OP_ADD, 32'h0, 32'h0, 32'h0000_0003, 16'h0000);
    send_op(saq_pkg::OP_ADD, 32'd100, 32'd0, 32'h0000_0001, 16'h0007);
    send_op(saq_pkg::OP_ADD, 32'd40, 32'd60, 32'h0000_0002, 16'h0007);
    send_op(saq_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, 32'h0000_0003, 16'h1234);
    send_op(saq_pkg::OP_POP, 32'd0, 32'd0, 32'd0, 16'd0);
    send_op(saq_pkg::OP_POP, 32'd1, 32'd0, 32'd0, 16'd0);
    send_op(saq_pkg::OP_POP, 32'd100, 32'd0, 32'd0, 16'd0);
    send_op(saq_pkg::OP_POP, 32'd101, 32'd0, 32'd0, 16'd0);
    send_op(saq_pkg::OP_POP, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0);
    send_op(saq_pkg::OP_POP, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0);
  endtask

  // Cancel by both keys, purge of interleaved sessions, then empty out
  task automatic test_cancel_purge();
    send_op(saq_pkg::OP_ADD, 32'd10, 32'd0, 32'h8000_0001, 16'h0005);
    send_op(saq_pkg::OP_ADD, 32'd10, 32'd0, 32'h7FFF_FFFE, 16'h0005);
    send_op(saq_pkg::OP_ADD, 32'd20, 32'd0, 32'h8000_0001, 16'h0005);
    send_op(saq_pkg::OP_ADD, 32'd5, 32'd0, 32'h8000_0001, 16'h0006);
    send_op(saq_pkg::OP_CANCEL, 32'd0, 32'd0, 32'h7FFF_FFFE, 16'h0006);
    send_op(saq_pkg::OP_CANCEL, 32'd0, 32'd0, 32'h8000_0001, 16'h0005);
    send_op(saq_pkg::OP_PURGE, 32'd0, 32'd0, 32'h8000_0001, 16'h0000);
    send_op(saq_pkg::OP_PURGE, 32'd0, 32'd0, 32'h7FFF_FFFE, 16'h0000);
    send_op(saq_pkg::OP_PURGE, 32'd0, 32'd0, 32'hA5A5_A5A5, 16'h0000);
    send_op(saq_pkg::OP_PURGE, 32'd0, 32'd0, 32'h5A5A_5A5A, 16'h0000);
    send_op(saq_pkg::OP_PURGE, 32'd0, 32'd0, 32'h0000_0003, 16'h0000);
  endtask

  // Fill to capacity, push rejected adds, then thin out by session
  task automatic test_fill_and_reject();
    int round;
    for (round = 0; round < 3; round++) begin
      while (held < saq_pkg::DEPTH) begin
        tick = tick + $urandom_range(3);
        send_op(saq_pkg::OP_ADD, tick, pick_delay(), pick_session(), pick_alarm());
      end
      repeat ($urandom_range(1, 3))
        send_op(saq_pkg::OP_ADD, $urandom(), $urandom(), $urandom(),
                saq_pkg::ALM_W'($urandom()));
      repeat ($urandom_range(2, 5))
        send_op(saq_pkg::OP_PURGE, $urandom(), $urandom(), pick_session(),
                saq_pkg::ALM_W'($urandom()));
    end
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_random_op();
  endtask

  // Random operations with neither side idling
  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (200) send_random_op();
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_add_edges();
    test_cancel_purge();
    pause_until_drained();
    test_fill_and_reject();
    test_random_mix(400);
    pause_until_drained();
    test_back_to_back();
    test_random_mix(420);
    pause_until_drained();
    repeat (saq_pkg::DEPTH + 8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0)
      $display("sorted_alarm_queue_tb passed");
    else
      $display("sorted_alarm_queue_tb failed");
    $finish;
  end

endmodule
